/* src/mspc_pkg.sv */
package mspc_pkg;

    localparam int UC_STEP_W = 4;
    localparam int NUM_W     = 48;
    localparam int QUOT_W    = 16;
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 17;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = PROD_W;
    localparam int DRIVE_W   = 9;
    localparam int DRIVE_MAX = 255;

    localparam logic [15:0] MS_PER_MIN = 16'd60000;
    localparam logic [14:0] SPEED_SAT  = 15'h7fff;

    typedef logic [UC_STEP_W-1:0] step_t;

    typedef enum logic [2:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_SPEED_LIM  = 3'd3,
        REG_TICKS_TURN = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NO_BEAT,
        COND_DT_ZERO,
        COND_DIV_BUSY,
        COND_OUT_BUSY
    } cond_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_DIFF,
        ACT_NUM,
        ACT_DEN,
        ACT_SPEED,
        ACT_ERR,
        ACT_SUM,
        ACT_ACC_LOAD,
        ACT_ACC_ADD,
        ACT_OUT
    } act_t;

    typedef enum logic [2:0] {
        MUL_MAG,
        MUL_DEN,
        MUL_P,
        MUL_I,
        MUL_D
    } mul_sel_t;

    typedef struct packed {
        logic     in_ready;
        act_t     act;
        mul_sel_t mul_sel;
        cond_t    cond;
        step_t    target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic dt_zero;
        logic div_busy;
        logic out_busy;
    } stat_t;

    localparam step_t STEP_WAIT     = 4'd0;
    localparam step_t STEP_DIFF     = 4'd1;
    localparam step_t STEP_MUL_MAG  = 4'd2;
    localparam step_t STEP_MUL_DEN  = 4'd3;
    localparam step_t STEP_DIV_GO   = 4'd4;
    localparam step_t STEP_DIV_WAIT = 4'd5;
    localparam step_t STEP_SPEED    = 4'd6;
    localparam step_t STEP_ERR      = 4'd7;
    localparam step_t STEP_SUM      = 4'd8;
    localparam step_t STEP_ACC_P    = 4'd9;
    localparam step_t STEP_ACC_I    = 4'd10;
    localparam step_t STEP_ACC_D    = 4'd11;
    localparam step_t STEP_OUT      = 4'd12;
    localparam step_t STEP_RETURN   = 4'd13;

    function automatic ctrl_t uc_rom(input step_t step);
        ctrl_t w;
        w = '{in_ready: 1'b0, act: ACT_NONE, mul_sel: MUL_P, cond: COND_NEXT,
              target: STEP_WAIT};
        unique case (step)
            STEP_WAIT: begin
                w.in_ready = 1'b1;
                w.act      = ACT_LOAD;
                w.cond     = COND_NO_BEAT;
                w.target   = STEP_WAIT;
            end
            STEP_DIFF: begin
                w.act    = ACT_DIFF;
                w.cond   = COND_DT_ZERO;
                w.target = STEP_ERR;
            end
            STEP_MUL_MAG: begin
                w.mul_sel = MUL_MAG;
            end
            STEP_MUL_DEN: begin
                w.act     = ACT_NUM;
                w.mul_sel = MUL_DEN;
            end
            STEP_DIV_GO: begin
                w.act = ACT_DEN;
            end
            STEP_DIV_WAIT: begin
                w.cond   = COND_DIV_BUSY;
                w.target = STEP_DIV_WAIT;
            end
            STEP_SPEED: begin
                w.act = ACT_SPEED;
            end
            STEP_ERR: begin
                w.act = ACT_ERR;
            end
            STEP_SUM: begin
                w.act     = ACT_SUM;
                w.mul_sel = MUL_P;
            end
            STEP_ACC_P: begin
                w.act     = ACT_ACC_LOAD;
                w.mul_sel = MUL_I;
            end
            STEP_ACC_I: begin
                w.act     = ACT_ACC_ADD;
                w.mul_sel = MUL_D;
            end
            STEP_ACC_D: begin
                w.act = ACT_ACC_ADD;
            end
            STEP_OUT: begin
                w.act    = ACT_OUT;
                w.cond   = COND_OUT_BUSY;
                w.target = STEP_OUT;
            end
            STEP_RETURN: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_WAIT;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

/* src/mspc_seq.sv */
module mspc_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  mspc_pkg::stat_t stat,
    output mspc_pkg::ctrl_t ctrl
);

    mspc_pkg::step_t step_reg;
    mspc_pkg::step_t step_next;
    logic            jump;

    assign ctrl = mspc_pkg::uc_rom(step_reg);

    always_comb begin
        unique case (ctrl.cond)
            mspc_pkg::COND_NEXT:     jump = 1'b0;
            mspc_pkg::COND_ALWAYS:   jump = 1'b1;
            mspc_pkg::COND_NO_BEAT:  jump = !stat.in_valid;
            mspc_pkg::COND_DT_ZERO:  jump = stat.dt_zero;
            mspc_pkg::COND_DIV_BUSY: jump = stat.div_busy;
            mspc_pkg::COND_OUT_BUSY: jump = stat.out_busy;
            default:                 jump = 1'b1;
        endcase
    end

    always_comb begin
        if (jump) begin
            step_next = ctrl.target;
        end else begin
            step_next = step_reg + mspc_pkg::step_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= mspc_pkg::STEP_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

/* src/mspc_div.sv */
module mspc_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [mspc_pkg::NUM_W-1:0]  num,
    input  logic [mspc_pkg::NUM_W-1:0]  den,
    output logic                        busy,
    output logic [mspc_pkg::QUOT_W-1:0] quot
);

    localparam int NUM_W  = mspc_pkg::NUM_W;
    localparam int QUOT_W = mspc_pkg::QUOT_W;
    localparam int DVS_W  = NUM_W + QUOT_W - 1;
    localparam int CNT_W  = $clog2(QUOT_W);

    logic [DVS_W-1:0]  dvs_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              ge;
    logic [NUM_W-1:0]  rem_sub;

    assign ge      = {{(QUOT_W-1){1'b0}}, rem_reg} >= dvs_reg;
    assign rem_sub = rem_reg - dvs_reg[NUM_W-1:0];
    assign busy    = busy_reg;
    assign quot    = quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && cnt_reg == '0) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            dvs_reg <= {den, {(QUOT_W-1){1'b0}}};
            cnt_reg <= CNT_W'(QUOT_W - 1);
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= rem_sub;
            end
            quot_reg <= {quot_reg[QUOT_W-2:0], ge};
            dvs_reg  <= dvs_reg >> 1;
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
    end

endmodule

/* src/mspc_dp.sv */
module mspc_dp #(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  mspc_pkg::ctrl_t                    ctrl,
    output mspc_pkg::stat_t                    stat,
    input  logic                               s_valid,
    input  logic [31:0]                        s_now_ms,
    input  logic signed [31:0]                 s_encoder_count,
    input  logic signed [15:0]                 s_target_speed,
    input  logic                               cfg_valid,
    input  logic [2:0]                         cfg_index,
    input  logic [15:0]                        cfg_data,
    input  logic                               m_ready,
    output logic                               m_valid,
    output logic signed [15:0]                 m_measured_speed,
    output logic signed [mspc_pkg::DRIVE_W-1:0] m_drive_value,
    output logic [7:0]                         m_leg_a_duty,
    output logic [7:0]                         m_leg_b_duty,
    output logic                               div_start,
    output logic [mspc_pkg::NUM_W-1:0]         div_num,
    output logic [mspc_pkg::NUM_W-1:0]         div_den,
    input  logic                               div_busy,
    input  logic [mspc_pkg::QUOT_W-1:0]        div_quot
);

    localparam int NUM_W   = mspc_pkg::NUM_W;
    localparam int ACC_W   = mspc_pkg::ACC_W;
    localparam int PROD_W  = mspc_pkg::PROD_W;
    localparam int DRIVE_W = mspc_pkg::DRIVE_W;
    localparam logic signed [ACC_W-1:0] DRV_HI = ACC_W'(mspc_pkg::DRIVE_MAX);
    localparam logic signed [ACC_W-1:0] DRV_LO = -DRV_HI;
    localparam logic [ACC_W-1:0] FRAC_MASK = (ACC_W'(1) << GAIN_FRAC_BITS) - ACC_W'(1);

    logic signed [15:0] prop_gain_reg;
    logic signed [15:0] integ_gain_reg;
    logic signed [15:0] deriv_gain_reg;
    logic [14:0]        speed_limit_reg;
    logic [15:0]        ticks_turn_reg;

    logic [31:0]        last_time_reg;
    logic [31:0]        last_count_reg;
    logic [15:0]        speed_reg;
    logic [31:0]        error_sum_reg;
    logic [16:0]        last_error_reg;

    logic [31:0]        now_reg;
    logic [31:0]        count_reg;
    logic [15:0]        target_reg;
    logic [31:0]        dt_reg;
    logic [31:0]        mag_reg;
    logic               neg_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [16:0]        err_reg;
    logic [17:0]        derr_reg;
    logic signed [PROD_W-1:0] mul_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic               m_valid_reg;
    logic [15:0]        speed_out_reg;
    logic [DRIVE_W-1:0] drive_out_reg;
    logic [7:0]         leg_a_reg;
    logic [7:0]         leg_b_reg;

    logic [31:0]        dt_now;
    logic [32:0]        delta;
    logic [31:0]        mag_now;
    logic [15:0]        ticks_eff;
    logic signed [mspc_pkg::MUL_A_W-1:0] mul_a;
    logic signed [mspc_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0] product;
    logic [14:0]        q_mag;
    logic [15:0]        speed_now;
    logic signed [16:0] tgt_ext;
    logic signed [16:0] lim_pos;
    logic signed [16:0] lim_neg;
    logic signed [16:0] tgt_clamp;
    logic [16:0]        err_now;
    logic [32:0]        sum_wide;
    logic [31:0]        sum_sat;
    logic [17:0]        derr_now;
    logic signed [ACC_W-1:0] acc_biased;
    logic signed [ACC_W-1:0] acc_shr;
    logic [DRIVE_W-1:0] drive_now;
    logic [7:0]         leg_a_now;
    logic [7:0]         leg_b_now;
    logic               out_busy;
    logic               out_load;

    assign dt_now    = now_reg - last_time_reg;
    assign delta     = {count_reg[31], count_reg} - {last_count_reg[31], last_count_reg};
    assign mag_now   = delta[32] ? 32'(-delta) : delta[31:0];
    assign ticks_eff = (ticks_turn_reg == '0) ? 16'd1 : ticks_turn_reg;

    always_comb begin
        unique case (ctrl.mul_sel)
            mspc_pkg::MUL_MAG: begin
                mul_a = {1'b0, mag_reg};
                mul_b = {1'b0, mspc_pkg::MS_PER_MIN};
            end
            mspc_pkg::MUL_DEN: begin
                mul_a = {1'b0, dt_reg};
                mul_b = {1'b0, ticks_eff};
            end
            mspc_pkg::MUL_P: begin
                mul_a = {{16{err_reg[16]}}, err_reg};
                mul_b = {prop_gain_reg[15], prop_gain_reg};
            end
            mspc_pkg::MUL_I: begin
                mul_a = {error_sum_reg[31], error_sum_reg};
                mul_b = {integ_gain_reg[15], integ_gain_reg};
            end
            mspc_pkg::MUL_D: begin
                mul_a = {{15{derr_reg[17]}}, derr_reg};
                mul_b = {deriv_gain_reg[15], deriv_gain_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    assign q_mag     = div_quot[mspc_pkg::QUOT_W-1] ? mspc_pkg::SPEED_SAT : div_quot[14:0];
    assign speed_now = neg_reg ? 16'(-{1'b0, q_mag}) : {1'b0, q_mag};

    assign tgt_ext = {target_reg[15], target_reg};
    assign lim_pos = $signed({2'b00, speed_limit_reg});
    assign lim_neg = -lim_pos;

    always_comb begin
        if (tgt_ext > lim_pos) begin
            tgt_clamp = lim_pos;
        end else if (tgt_ext < lim_neg) begin
            tgt_clamp = lim_neg;
        end else begin
            tgt_clamp = tgt_ext;
        end
    end

    assign err_now  = tgt_clamp - {speed_reg[15], speed_reg};
    assign sum_wide = {error_sum_reg[31], error_sum_reg} + {{16{err_reg[16]}}, err_reg};

    always_comb begin
        if (err_reg == '0) begin
            sum_sat = '0;
        end else if (sum_wide[32] != sum_wide[31]) begin
            sum_sat = sum_wide[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        end else begin
            sum_sat = sum_wide[31:0];
        end
    end

    assign derr_now = {err_reg[16], err_reg} - {last_error_reg[16], last_error_reg};

    assign acc_biased = acc_reg + $signed(acc_reg[ACC_W-1] ? FRAC_MASK : '0);
    assign acc_shr    = acc_biased >>> GAIN_FRAC_BITS;

    always_comb begin
        if (acc_shr > DRV_HI) begin
            drive_now = DRIVE_W'(DRV_HI);
        end else if (acc_shr < DRV_LO) begin
            drive_now = DRIVE_W'(DRV_LO);
        end else begin
            drive_now = acc_shr[DRIVE_W-1:0];
        end
    end

    always_comb begin
        leg_a_now = '0;
        leg_b_now = '0;
        if (drive_now[DRIVE_W-1]) begin
            leg_a_now = 8'(-drive_now);
        end else begin
            leg_b_now = drive_now[7:0];
        end
    end

    assign out_busy = m_valid_reg && !m_ready;
    assign out_load = (ctrl.act == mspc_pkg::ACT_OUT) && !out_busy;

    assign stat.in_valid = s_valid;
    assign stat.dt_zero  = (dt_now == '0);
    assign stat.div_busy = div_busy;
    assign stat.out_busy = out_busy;

    assign div_start = (ctrl.act == mspc_pkg::ACT_DEN);
    assign div_num   = num_reg;
    assign div_den   = mul_reg[NUM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            speed_limit_reg <= 15'd330;
            ticks_turn_reg  <= 16'd1;
            last_time_reg   <= '0;
            last_count_reg  <= '0;
            speed_reg       <= '0;
            error_sum_reg   <= '0;
            last_error_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    mspc_pkg::REG_PROP_GAIN:  prop_gain_reg   <= cfg_data;
                    mspc_pkg::REG_INTEG_GAIN: integ_gain_reg  <= cfg_data;
                    mspc_pkg::REG_DERIV_GAIN: deriv_gain_reg  <= cfg_data;
                    mspc_pkg::REG_SPEED_LIM:  speed_limit_reg <= cfg_data[14:0];
                    mspc_pkg::REG_TICKS_TURN: ticks_turn_reg  <= cfg_data;
                    default: ;
                endcase
            end
            unique case (ctrl.act)
                mspc_pkg::ACT_DIFF: begin
                    last_time_reg  <= now_reg;
                    last_count_reg <= count_reg;
                end
                mspc_pkg::ACT_SPEED: begin
                    speed_reg <= speed_now;
                end
                mspc_pkg::ACT_SUM: begin
                    error_sum_reg  <= sum_sat;
                    last_error_reg <= err_reg;
                end
                default: ;
            endcase
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mul_reg <= product;
        unique case (ctrl.act)
            mspc_pkg::ACT_LOAD: begin
                if (s_valid) begin
                    now_reg    <= s_now_ms;
                    count_reg  <= s_encoder_count;
                    target_reg <= s_target_speed;
                end
            end
            mspc_pkg::ACT_DIFF: begin
                dt_reg  <= dt_now;
                mag_reg <= mag_now;
                neg_reg <= delta[32];
            end
            mspc_pkg::ACT_NUM:      num_reg  <= mul_reg[NUM_W-1:0];
            mspc_pkg::ACT_ERR:      err_reg  <= err_now;
            mspc_pkg::ACT_SUM:      derr_reg <= derr_now;
            mspc_pkg::ACT_ACC_LOAD: acc_reg  <= mul_reg;
            mspc_pkg::ACT_ACC_ADD:  acc_reg  <= acc_reg + mul_reg;
            default: ;
        endcase
        if (out_load) begin
            speed_out_reg <= speed_reg;
            drive_out_reg <= drive_now;
            leg_a_reg     <= leg_a_now;
            leg_b_reg     <= leg_b_now;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_measured_speed = speed_out_reg;
    assign m_drive_value    = drive_out_reg;
    assign m_leg_a_duty     = leg_a_reg;
    assign m_leg_b_duty     = leg_b_reg;

    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> drive_out_reg != {1'b1, {(DRIVE_W-1){1'b0}}})
        else $error("drive value outside the clamp range");

    a_leg_split: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((drive_out_reg[DRIVE_W-1] && leg_b_reg == 8'd0
                          && 8'(leg_a_reg + drive_out_reg[7:0]) == 8'd0)
                      || (!drive_out_reg[DRIVE_W-1] && leg_a_reg == 8'd0
                          && leg_b_reg == drive_out_reg[7:0])))
        else $error("leg duties do not match drive value");

    a_speed_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> speed_out_reg != 16'h8000)
        else $error("measured speed escaped saturation");

    a_sum_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.act == mspc_pkg::ACT_SUM && err_reg == '0) |=> error_sum_reg == '0)
        else $error("error sum not cleared on zero error");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

endmodule

/* src/motor_speed_pid_controller.sv */
// Channel  Handshake              Payload
// s_       s_valid / s_ready      s_now_ms, s_encoder_count, s_target_speed
// m_       m_valid / m_ready      m_measured_speed, m_drive_value, m_leg_a_duty, m_leg_b_duty
// cfg_     cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item at a time: s_ready is high only while the program waits for a beat. When the
// timestamp has not moved since the last beat, the speed steps are skipped. The divider
// runs a 16-step quotient loop; the shared 33x17 multiplier forms up to five products per item.
// Reset (aresetn low, synchronous) restores gains, limit, tick count and loop state.
// A stalled result register holds the program at its output step.
// cfg_ready is always high.
module motor_speed_pid_controller #(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_now_ms,
    input  logic signed [31:0] s_encoder_count,
    input  logic signed [15:0] s_target_speed,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_measured_speed,
    output logic signed [8:0]  m_drive_value,
    output logic [7:0]         m_leg_a_duty,
    output logic [7:0]         m_leg_b_duty,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    mspc_pkg::ctrl_t                    ctrl;
    mspc_pkg::stat_t                    stat;
    logic                               div_start;
    logic [mspc_pkg::NUM_W-1:0]         div_num;
    logic [mspc_pkg::NUM_W-1:0]         div_den;
    logic                               div_busy;
    logic [mspc_pkg::QUOT_W-1:0]        div_quot;

    assign s_ready   = ctrl.in_ready;
    assign cfg_ready = 1'b1;

    mspc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    mspc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    mspc_dp #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl             (ctrl),
        .stat             (stat),
        .s_valid          (s_valid),
        .s_now_ms         (s_now_ms),
        .s_encoder_count  (s_encoder_count),
        .s_target_speed   (s_target_speed),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_measured_speed (m_measured_speed),
        .m_drive_value    (m_drive_value),
        .m_leg_a_duty     (m_leg_a_duty),
        .m_leg_b_duty     (m_leg_b_duty),
        .div_start        (div_start),
        .div_num          (div_num),
        .div_den          (div_den),
        .div_busy         (div_busy),
        .div_quot         (div_quot)
    );

endmodule
